@@ rtl/rqd_pkg.sv @@
// rqd_pkg: shared types and constants of the ready queue job dispatcher
// no dependencies; read by the channel interfaces and the core

package rqd_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 16;

  localparam int IDX_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W       = 16;
  localparam int FIELD_W    = 16;
  localparam int QUANT_W    = 16;
  localparam int COUNT_W    = 5;
  localparam int CMP_W      = (TIME_BITS > QUANT_W) ? TIME_BITS : QUANT_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [QUANT_W-1:0] QUANTUM_RESET = QUANT_W'(10);

  localparam logic REQ_ADD      = 1'b0;
  localparam logic REQ_DISPATCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    MODE_FCFS  = 2'd0,
    MODE_SJF   = 2'd1,
    MODE_RR    = 2'd2,
    MODE_UNDEF = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_BADMODE = 2'd3
  } status_e;

  typedef struct packed {
    logic               req_type;
    logic [FIELD_W-1:0] job_id;
    logic [FIELD_W-1:0] job_burst;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] granted_id;
    logic [FIELD_W-1:0] run_time;
    logic               job_done;
    logic [COUNT_W-1:0] queue_count;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [TIME_BITS-1:0] burst;
    logic [TIME_BITS-1:0] rem;
  } entry_t;

endpackage

@@ rtl/rqd_if.sv @@
// rqd_if: valid/ready channels for requests and responses of the dispatcher
// depends on rqd_pkg for the payload structs

interface rqd_req_if;
  import rqd_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface rqd_rsp_if;
  import rqd_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/rqd_ram.sv @@
// rqd_ram: generic single write, single read ram with registered read data
// no dependencies

module rqd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ready_queue_job_dispatcher_core.sv @@
// ready_queue_job_dispatcher_core: fcfs / sjf / round robin ready queue
// depends on rqd_pkg, rqd_if (rqd_req_if, rqd_rsp_if) and rqd_ram
//
//   channel  dir  handshake            payload
//   req_i    in   valid/ready          req_type, job_id, job_burst
//   rsp_o    out  valid/ready          status, granted_id, run_time, job_done, queue_count
//   cfg      in   cfg_we_i (no wait)   cfg_idx_i, cfg_wdata_i
//
// add, empty and bad-mode requests load their response in the accept cycle
// dispatch: the queue ram has one read port, so the sjf scan reads every entry
// in turn (fcfs/rr read only the head), compaction moves each entry behind the
// pick one slot toward the head, a round robin job that overruns its quantum is
// requeued at the tail with the remainder, then the response is loaded; no
// clearing pass after reset
// req_i.ready is low while a dispatch is in flight or a response is stalled

module ready_queue_job_dispatcher_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rqd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rqd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  rqd_req_if.sink                        req_i,
  rqd_rsp_if.source                      rsp_o
);
  import rqd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_TAIL  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     occ_q, occ_d;
  mode_e                mode_q;
  logic [QUANT_W-1:0]   quantum_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     lim_q, lim_d;
  logic [CNT_W-1:0]     ridx_q, ridx_d;
  logic [CNT_W-1:0]     pick_q, pick_d;
  logic                 rv_q, rv_d;
  entry_t               best_q, best_d;
  logic [FIELD_W-1:0]   run_q, run_d;
  logic                 fin_q, fin_d;
  rsp_t                 rsp_q, rsp_d;
  logic                 rsp_valid_q, rsp_valid_d;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  entry_t               ram_wdata;
  logic                 ram_re;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t               rd_entry;

  logic                 out_free;
  logic                 req_fire;
  logic [CMP_W:0]       diff;
  logic                 fits_slice;

  rqd_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(cnt_q[IDX_W-1:0]),
    .rdata_o(ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // shared remaining vs quantum unit
  assign diff       = {1'b0, CMP_W'(best_q.rem)} - {1'b0, CMP_W'(quantum_q)};
  assign fits_slice = diff[CMP_W] || (diff[CMP_W-1:0] == '0);

  assign out_free      = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready   = (state_q == S_IDLE) && out_free;
  assign req_fire      = req_i.valid && req_i.ready;
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    cnt_d       = cnt_q;
    lim_d       = lim_q;
    ridx_d      = ridx_q;
    pick_d      = pick_q;
    rv_d        = rv_q;
    best_d      = best_q;
    run_d       = run_q;
    fin_d       = fin_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    ram_we      = 1'b0;
    ram_waddr   = occ_q[IDX_W-1:0];
    ram_wdata   = best_q;
    ram_re      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          if (req_i.payload.req_type == REQ_ADD) begin
            rsp_valid_d = 1'b1;
            rsp_d       = '0;
            if (occ_q == CNT_W'(QUEUE_DEPTH)) begin
              rsp_d.status      = STAT_FULL;
              rsp_d.queue_count = COUNT_W'(occ_q);
            end else begin
              ram_we            = 1'b1;
              ram_wdata.id      = ID_W'(req_i.payload.job_id);
              ram_wdata.burst   = TIME_BITS'(req_i.payload.job_burst);
              ram_wdata.rem     = TIME_BITS'(req_i.payload.job_burst);
              occ_d             = occ_q + CNT_W'(1);
              rsp_d.status      = STAT_OK;
              rsp_d.queue_count = COUNT_W'(occ_q + CNT_W'(1));
            end
          end else if (mode_q == MODE_UNDEF) begin
            rsp_valid_d       = 1'b1;
            rsp_d             = '0;
            rsp_d.status      = STAT_BADMODE;
            rsp_d.queue_count = COUNT_W'(occ_q);
          end else if (occ_q == '0) begin
            rsp_valid_d       = 1'b1;
            rsp_d             = '0;
            rsp_d.status      = STAT_EMPTY;
            rsp_d.queue_count = COUNT_W'(occ_q);
          end else begin
            cnt_d   = '0;
            rv_d    = 1'b0;
            lim_d   = (mode_q == MODE_SJF) ? occ_q : CNT_W'(1);
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cnt_q < lim_q) begin
          ram_re = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
        end
        rv_d   = cnt_q < lim_q;
        ridx_d = cnt_q;
        if (rv_q) begin
          // strict compare keeps the entry nearest the head on ties
          if (ridx_q == '0 || rd_entry.burst < best_q.burst) begin
            best_d = rd_entry;
            pick_d = ridx_q;
          end
          if (ridx_q == lim_q - CNT_W'(1)) begin
            cnt_d   = pick_d + CNT_W'(1);
            rv_d    = 1'b0;
            state_d = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        if (cnt_q < occ_q) begin
          ram_re = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
        end
        rv_d   = cnt_q < occ_q;
        ridx_d = cnt_q;
        if (rv_q) begin
          ram_we    = 1'b1;
          ram_waddr = IDX_W'(ridx_q - CNT_W'(1));
          ram_wdata = rd_entry;
        end
        if (!(cnt_q < occ_q) && !rv_q) begin
          occ_d = occ_q - CNT_W'(1);
          if (mode_q == MODE_RR && !fits_slice) begin
            state_d = S_TAIL;
          end else begin
            run_d   = FIELD_W'(best_q.rem);
            fin_d   = 1'b1;
            state_d = S_DONE;
          end
        end
      end
      S_TAIL: begin
        ram_we        = 1'b1;
        ram_waddr     = occ_q[IDX_W-1:0];
        ram_wdata     = best_q;
        ram_wdata.rem = TIME_BITS'(diff[CMP_W-1:0]);
        occ_d         = occ_q + CNT_W'(1);
        run_d         = FIELD_W'(quantum_q);
        fin_d         = 1'b0;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          rsp_valid_d       = 1'b1;
          rsp_d.status      = STAT_OK;
          rsp_d.granted_id  = FIELD_W'(best_q.id);
          rsp_d.run_time    = run_q;
          rsp_d.job_done    = fin_q;
          rsp_d.queue_count = COUNT_W'(occ_q);
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      mode_q      <= MODE_FCFS;
      quantum_q   <= QUANTUM_RESET;
      rv_q        <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      rv_q        <= rv_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_POLICY:  mode_q    <= mode_e'(cfg_wdata_i[1:0]);
          REG_QUANTUM: quantum_q <= cfg_wdata_i[QUANT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    lim_q  <= lim_d;
    ridx_q <= ridx_d;
    pick_q <= pick_d;
    best_q <= best_d;
    run_q  <= run_d;
    fin_q  <= fin_d;
    rsp_q  <= rsp_d;
  end

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

  a_tail_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TAIL) |-> (occ_q < CNT_W'(QUEUE_DEPTH)))
    else $error("requeue without a free slot");

  a_shift_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && rv_q) |-> (ridx_q != '0 && ridx_q < occ_q))
    else $error("compaction write outside the queue");

  a_dispatch_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && state_d != S_SHIFT) |=> (occ_q == $past(occ_q) - CNT_W'(1)))
    else $error("dispatch did not remove one job");

endmodule
